/* design/pep_pkg.sv */
package pep_pkg;

  // Field widths of the ports.
  localparam int COORD_BITS = 12;
  localparam int DELTA_W    = 12;
  localparam int BTN_W      = 3;
  localparam int STAMP_W    = 32;
  localparam int KIND_W     = 2;
  localparam int BNUM_W     = 2;

  // Configuration register widths.
  localparam int THR_W      = 11;
  localparam int NUM_W      = 8;
  localparam int DEN_W      = 8;
  localparam int SIZE_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // Acceleration arithmetic widths.
  localparam int MAG_W  = DELTA_W;
  localparam int PROD_W = MAG_W + NUM_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SUM_W  = ACC_W + 1;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int BND_W  = (SIZE_W > COORD_BITS) ? SIZE_W : COORD_BITS;

  // Result slots of one input: motion first, then buttons 1 to 3.
  localparam int SLOTS  = 4;
  localparam int SLOT_W = 2;
  localparam logic [SLOT_W-1:0] SLOT_MOTION = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_FINAL  = SLOT_W'(SLOTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_NUMERATOR     = 3'd1,
    CFG_DENOMINATOR   = 3'd2,
    CFG_SCREEN_WIDTH  = 3'd3,
    CFG_SCREEN_HEIGHT = 3'd4
  } cfg_index_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOTION  = 2'd2
  } kind_t;

  localparam logic [THR_W-1:0]      RST_THRESHOLD   = THR_W'(2);
  localparam logic [NUM_W-1:0]      RST_NUMERATOR   = NUM_W'(2);
  localparam logic [DEN_W-1:0]      RST_DENOMINATOR = DEN_W'(1);
  localparam logic [SIZE_W-1:0]     RST_WIDTH       = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0]     RST_HEIGHT      = SIZE_W'(768);
  localparam logic [COORD_BITS-1:0] RST_POS_X       = COORD_BITS'(RST_WIDTH / 2);
  localparam logic [COORD_BITS-1:0] RST_POS_Y       = COORD_BITS'(RST_HEIGHT / 2);
  localparam logic [BTN_W-1:0]      RST_BUTTONS     = '1;
  localparam logic [COORD_BITS-1:0] COORD_MAX       = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              axis_y;
    logic              div_start;
    logic              apply;
    logic              emit;
    logic [SLOT_W-1:0] slot;
    logic              finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             op_flush;
    logic             delta_zero;
    logic             over_thr;
    logic             div_busy;
    logic             out_free;
    logic [SLOTS-1:0] slot_valid;
  } status_t;

endpackage

/* design/pep_div.sv */
module pep_div import pep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              busy,
  output logic [PROD_W-1:0] quotient
);

  logic [PROD_W-1:0] quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(PROD_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      // A zero denominator divides by one.
      den_r <= (divisor == '0) ? DEN_W'(1) : divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* design/pep_datapath.sv */
module pep_datapath import pep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_op,
  input  logic [DELTA_W-1:0]        in_delta_x,
  input  logic [DELTA_W-1:0]        in_delta_y,
  input  logic [BTN_W-1:0]          in_button_bits,
  input  logic [STAMP_W-1:0]        in_stamp,
  input  cmd_t                      cmd,
  output status_t                   status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [KIND_W-1:0]         out_event_kind,
  output logic [BNUM_W-1:0]         out_button_number,
  output logic [COORD_BITS-1:0]     out_pos_x,
  output logic [COORD_BITS-1:0]     out_pos_y,
  output logic [STAMP_W-1:0]        out_event_time,
  output logic                      out_last
);

  // Largest coordinate allowed by a screen dimension.
  function automatic logic [COORD_BITS-1:0] screen_bound(input logic [SIZE_W-1:0] size);
    logic [BND_W-1:0] lim;
    lim = (size == '0) ? '0 : BND_W'(size) - BND_W'(1);
    if (lim > BND_W'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return lim[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [SUM_W-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
    if (v[SUM_W-1]) begin
      return '0;
    end
    if (v > SUM_W'(hi)) begin
      return hi;
    end
    return v[COORD_BITS-1:0];
  endfunction

  logic [THR_W-1:0]      thr_r;
  logic [NUM_W-1:0]      num_r;
  logic [DEN_W-1:0]      den_r;
  logic [SIZE_W-1:0]     width_r;
  logic [SIZE_W-1:0]     height_r;

  logic [COORD_BITS-1:0] cur_x_r;
  logic [COORD_BITS-1:0] cur_y_r;
  logic [BTN_W-1:0]      btn_r;
  logic                  pend_r;
  logic [STAMP_W-1:0]    prior_r;

  logic                  op_r;
  logic [DELTA_W-1:0]    dx_r;
  logic [DELTA_W-1:0]    dy_r;
  logic [BTN_W-1:0]      keys_r;
  logic [STAMP_W-1:0]    stamp_r;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [BNUM_W-1:0]     out_bnum_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [STAMP_W-1:0]    out_time_r;
  logic                  out_last_r;

  logic [DELTA_W-1:0]    d_sel;
  logic                  d_neg;
  logic [MAG_W-1:0]      mag;
  logic                  over;
  logic [MAG_W-1:0]      excess;
  logic [PROD_W-1:0]     prod;
  logic                  div_busy;
  logic [PROD_W-1:0]     quo;
  logic [ACC_W-1:0]      acc;
  logic [COORD_BITS-1:0] cur_sel;
  logic                  add_dir;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      x_pre;
  logic [SUM_W-1:0]      y_pre;
  logic [COORD_BITS-1:0] bound_x;
  logic [COORD_BITS-1:0] bound_y;
  logic [SLOTS-1:0]      slot_valid;
  logic                  later;
  logic                  slot_bit;
  logic                  out_free;

  // Magnitude of the selected delta and its excess over the threshold.
  assign d_sel  = cmd.axis_y ? dy_r : dx_r;
  assign d_neg  = d_sel[DELTA_W-1];
  assign mag    = d_neg ? (~d_sel + MAG_W'(1)) : d_sel;
  assign over   = (mag > MAG_W'(thr_r));
  assign excess = mag - MAG_W'(thr_r);
  assign prod   = PROD_W'(excess) * PROD_W'(num_r);

  pep_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (den_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign acc     = over ? (ACC_W'(thr_r) + ACC_W'(quo)) : ACC_W'(mag);
  assign cur_sel = cmd.axis_y ? cur_y_r : cur_x_r;
  // X follows the delta's sign, Y the opposite one.
  assign add_dir = (~cmd.axis_y) ^ d_neg;
  assign sum     = add_dir ? (SUM_W'(cur_sel) + SUM_W'(acc))
                           : (SUM_W'(cur_sel) - SUM_W'(acc));
  assign x_pre   = cmd.axis_y ? SUM_W'(cur_x_r) : sum;
  assign y_pre   = cmd.axis_y ? sum : SUM_W'(cur_y_r);
  assign bound_x = screen_bound(width_r);
  assign bound_y = screen_bound(height_r);

  always_comb begin
    slot_valid[SLOT_MOTION] = pend_r & (op_r | (keys_r != btn_r));
    for (int k = 1; k < SLOTS; k++) begin
      slot_valid[k] = ~op_r & (keys_r[BTN_W-k] != btn_r[BTN_W-k]);
    end
  end

  always_comb begin
    later = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if ((SLOT_W'(k) > cmd.slot) && slot_valid[k]) begin
        later = 1'b1;
      end
    end
  end

  assign slot_bit = keys_r[BTN_W - 32'(cmd.slot)];
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_THRESHOLD;
      num_r    <= RST_NUMERATOR;
      den_r    <= RST_DENOMINATOR;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:     thr_r    <= cfg_data[THR_W-1:0];
        CFG_NUMERATOR:     num_r    <= cfg_data[NUM_W-1:0];
        CFG_DENOMINATOR:   den_r    <= cfg_data[DEN_W-1:0];
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= RST_POS_X;
      cur_y_r <= RST_POS_Y;
      btn_r   <= RST_BUTTONS;
      pend_r  <= 1'b0;
      prior_r <= '0;
    end else begin
      if (cmd.apply) begin
        cur_x_r <= clamp_coord(x_pre, bound_x);
        cur_y_r <= clamp_coord(y_pre, bound_y);
        pend_r  <= 1'b1;
      end
      if (cmd.emit && (cmd.slot == SLOT_MOTION)) begin
        pend_r <= 1'b0;
      end
      if (cmd.finish && !op_r) begin
        btn_r   <= keys_r;
        prior_r <= stamp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      dx_r    <= in_delta_x;
      dy_r    <= in_delta_y;
      keys_r  <= in_button_bits;
      stamp_r <= in_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r    <= cur_x_r;
      out_y_r    <= cur_y_r;
      out_last_r <= ~later;
      if (cmd.slot == SLOT_MOTION) begin
        out_kind_r <= KIND_MOTION;
        out_bnum_r <= '0;
        out_time_r <= prior_r;
      end else begin
        out_kind_r <= slot_bit ? KIND_RELEASE : KIND_PRESS;
        out_bnum_r <= BNUM_W'(cmd.slot);
        out_time_r <= stamp_r;
      end
    end
  end

  assign status.op_flush   = op_r;
  assign status.delta_zero = (d_sel == '0);
  assign status.over_thr   = over;
  assign status.div_busy   = div_busy;
  assign status.out_free   = out_free;
  assign status.slot_valid = slot_valid;

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_button_number = out_bnum_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_event_time    = out_time_r;
  assign out_last          = out_last_r;

endmodule

/* design/pep_ctrl.sv */
module pep_ctrl import pep_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_DIV   = 6'b000100,
    S_APPLY = 6'b001000,
    S_EMIT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic              axis_r, axis_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    slot_nxt      = slot_r;
    cmd           = '0;
    cmd.axis_y    = axis_r;
    cmd.slot      = slot_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (status.op_flush) begin
          state_nxt = S_EMIT;
        end else if (status.delta_zero) begin
          if (!axis_r) begin
            axis_nxt = 1'b1;
          end else begin
            state_nxt = S_EMIT;
          end
        end else if (status.over_thr) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // A slot with an event waits for room in the output register.
        if (!status.slot_valid[slot_r] || status.out_free) begin
          cmd.emit = status.slot_valid[slot_r];
          if (slot_r == SLOT_FINAL) begin
            state_nxt = S_DONE;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        axis_nxt   = 1'b0;
        slot_nxt   = SLOT_MOTION;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
      slot_r  <= SLOT_MOTION;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* design/pointer_event_processor_core.sv */
// Pointer event processor. Each input word is either a raw mouse report
// (X and Y deltas, an active-low mask of three buttons and a millisecond
// timestamp) or a flush. A report moves the pointer: each nonzero delta has
// its magnitude above the threshold register scaled by numerator over
// denominator, X is added and Y subtracted, and both coordinates are clamped
// to the configured screen after every step, which also marks motion as
// pending. When the buttons change, a pending motion word goes out first with
// the previous report's time, followed by one press or release word for each
// changed button in the order 1, 2, 3, stamped with the current report's
// time. A flush sends out the pending motion word, if there is one. The last
// result word of an input carries out_last; an input may also produce no
// words at all. One input word is handled at a time and in_stall stays high
// until it is finished. Each delta above the threshold also passes through
// the shared one-bit-per-cycle divider, and the result side can hold up the
// output through out_stall. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. A zero denominator
// acts as one and indexes past the screen height are ignored.
module pointer_event_processor_core import pep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic signed [DELTA_W-1:0] in_delta_x,
  input  logic signed [DELTA_W-1:0] in_delta_y,
  input  logic [BTN_W-1:0]          in_button_bits,
  input  logic [STAMP_W-1:0]        in_stamp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [KIND_W-1:0]         out_event_kind,
  output logic [BNUM_W-1:0]         out_button_number,
  output logic [COORD_BITS-1:0]     out_pos_x,
  output logic [COORD_BITS-1:0]     out_pos_y,
  output logic [STAMP_W-1:0]        out_event_time,
  output logic                      out_last
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences the steps of one word: latch, per-axis
  // acceleration and clamping, then the walk over the four result slots.
  pep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the pointer state, the divider and
  // the output register that decouples the result side.
  pep_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_delta_x        (in_delta_x),
    .in_delta_y        (in_delta_y),
    .in_button_bits    (in_button_bits),
    .in_stamp          (in_stamp),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_button_number (out_button_number),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_event_time    (out_event_time),
    .out_last          (out_last)
  );

endmodule

/* dv/pointer_event_processor_core_tb.sv */
module pointer_event_processor_core_tb;
  import pep_pkg::*;

  // Operation codes of an input word.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // With a receiver that stalls most of the time, up to four results per word
  // and a sender that often idles, this limit is far out of reach for a correct
  // block.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles allowed for a word that produces no result to drain out of the block.
  localparam int DRAIN_CYCLES = 200;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 400;

  // One input word as the driver presents it.
  typedef struct packed {
    logic                      op;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          buttons;
    logic [STAMP_W-1:0]        stamp;
  } mouse_word_t;

  // One result word as the monitor sees it.
  typedef struct packed {
    kind_t                 kind;
    logic [BNUM_W-1:0]     button;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [STAMP_W-1:0]    event_time;
    logic                  last;
  } event_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = 1'b0;
  logic signed [DELTA_W-1:0] in_delta_x = '0;
  logic signed [DELTA_W-1:0] in_delta_y = '0;
  logic [BTN_W-1:0]          in_button_bits = '1;
  logic [STAMP_W-1:0]        in_stamp = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [KIND_W-1:0]         out_event_kind;
  logic [BNUM_W-1:0]         out_button_number;
  logic [COORD_BITS-1:0]     out_pos_x;
  logic [COORD_BITS-1:0]     out_pos_y;
  logic [STAMP_W-1:0]        out_event_time;
  logic                      out_last;

  pointer_event_processor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_delta_x       (in_delta_x),
    .in_delta_y       (in_delta_y),
    .in_button_bits   (in_button_bits),
    .in_stamp         (in_stamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_button_number(out_button_number),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_event_time   (out_event_time),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  // Words waiting to be offered, and the events the block still owes us.
  mouse_word_t pending_words[$];
  event_word_t owed_events[$];
  mouse_word_t on_offer;

  int error_count = 0;
  int events_seen = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 83;

  // The stimulus process asks for a long hold-off by bumping hold_asked; the
  // receiver notices the difference and runs the hold-off on its own counter.
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Our own copy of the pointer state and of the configuration registers.
  int                 pointer_x    = int'(RST_POS_X);
  int                 pointer_y    = int'(RST_POS_Y);
  logic [BTN_W-1:0]   held_buttons = RST_BUTTONS;
  bit                 motion_owed  = 1'b0;
  logic [STAMP_W-1:0] last_stamp   = '0;
  int                 accel_thr    = int'(RST_THRESHOLD);
  int                 accel_num    = int'(RST_NUMERATOR);
  int                 accel_den    = int'(RST_DENOMINATOR);
  int                 scr_width    = int'(RST_WIDTH);
  int                 scr_height   = int'(RST_HEIGHT);

  // State that shapes the random stream into plausible mouse traffic.
  logic [BTN_W-1:0]   gen_buttons = RST_BUTTONS;
  logic [STAMP_W-1:0] gen_stamp   = '0;

  task automatic note_error(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  // Only the part of a delta above the threshold is scaled; the quotient is
  // truncated and the sign of the raw delta is kept.
  function automatic int accelerate(input int d);
    int mag;
    int divisor;
    mag = (d < 0) ? -d : d;
    divisor = (accel_den == 0) ? 1 : accel_den;
    if (mag > accel_thr) mag = accel_thr + ((mag - accel_thr) * accel_num) / divisor;
    return (d < 0) ? -mag : mag;
  endfunction

  // Largest coordinate a screen size allows. A zero size pins the pointer at
  // zero, and no bound can exceed what the coordinate ports can carry.
  function automatic int limit_of(input int size);
    int lim;
    lim = (size == 0) ? 0 : size - 1;
    return (lim > int'(COORD_MAX)) ? int'(COORD_MAX) : lim;
  endfunction

  // Both coordinates are clamped after each step, whichever axis moved.
  task automatic clamp_pointer();
    int hx;
    int hy;
    hx = limit_of(scr_width);
    hy = limit_of(scr_height);
    pointer_x = (pointer_x < 0) ? 0 : ((pointer_x > hx) ? hx : pointer_x);
    pointer_y = (pointer_y < 0) ? 0 : ((pointer_y > hy) ? hy : pointer_y);
  endtask

  function automatic event_word_t make_event(input kind_t k, input int btn,
                                             input logic [STAMP_W-1:0] t);
    event_word_t e;
    e.kind       = k;
    e.button     = BNUM_W'(btn);
    e.pos_x      = COORD_BITS'(pointer_x);
    e.pos_y      = COORD_BITS'(pointer_y);
    e.event_time = t;
    e.last       = 1'b0;
    return e;
  endfunction

  // Works out the events that one accepted word causes and updates our copy of
  // the pointer state the way the block is meant to.
  task automatic predict_events(input mouse_word_t w);
    event_word_t batch[$];
    logic [BTN_W-1:0] mask;
    if (w.op == OP_FLUSH) begin
      if (motion_owed) begin
        batch.push_back(make_event(KIND_MOTION, 0, last_stamp));
        motion_owed = 1'b0;
      end
    end else begin
      if (w.dx != 0) begin
        pointer_x += accelerate(int'(w.dx));
        clamp_pointer();
        motion_owed = 1'b1;
      end
      // Positive Y means up, so it is taken away from the screen row.
      if (w.dy != 0) begin
        pointer_y -= accelerate(int'(w.dy));
        clamp_pointer();
        motion_owed = 1'b1;
      end
      if (w.buttons != held_buttons) begin
        // Motion goes out first and still carries the previous report's time.
        if (motion_owed) begin
          batch.push_back(make_event(KIND_MOTION, 0, last_stamp));
          motion_owed = 1'b0;
        end
        // Button 1 sits in the top bit. A set bit means the button is up.
        for (int b = 0; b < BTN_W; b++) begin
          mask = BTN_W'(1 << (BTN_W - 1 - b));
          if ((w.buttons & mask) != (held_buttons & mask))
            batch.push_back(make_event(((w.buttons & mask) != 0) ? KIND_RELEASE : KIND_PRESS,
                                       b + 1, w.stamp));
        end
      end
      held_buttons = w.buttons;
      last_stamp   = w.stamp;
    end
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) owed_events.push_back(batch[i]);
  endtask

  // Driver. A word that is on offer stays put until the block takes it; the
  // moment it is taken its events are predicted and the next word, if any,
  // may be offered in the same cycle unless the sender decides to idle.
  always @(posedge clk) begin
    mouse_word_t next_word;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_events(on_offer);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_word = pending_words.pop_front();
          on_offer = next_word;
          in_valid       <= 1'b1;
          in_op          <= next_word.op;
          in_delta_x     <= next_word.dx;
          in_delta_y     <= next_word.dy;
          in_button_bits <= next_word.buttons;
          in_stamp       <= next_word.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls at random, except during a requested hold-off, when it
  // keeps out_stall high throughout while hold_left counts down.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor. Every result word taken is checked against the oldest owed event.
  always @(posedge clk) begin
    event_word_t got;
    event_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind       = kind_t'(out_event_kind);
      got.button     = out_button_number;
      got.pos_x      = out_pos_x;
      got.pos_y      = out_pos_y;
      got.event_time = out_event_time;
      got.last       = out_last;
      if (owed_events.size() == 0) begin
        note_error($sformatf("result %0d not expected: kind %0d button %0d at (%0d,%0d)",
                             events_seen, got.kind, got.button, got.pos_x, got.pos_y));
      end else begin
        want = owed_events.pop_front();
        if (got !== want)
          note_error($sformatf({"result %0d: want kind %0d btn %0d (%0d,%0d) t %0h last %0d,",
                                " got kind %0d btn %0d (%0d,%0d) t %0h last %0d"},
                               events_seen, want.kind, want.button, want.pos_x, want.pos_y,
                               want.event_time, want.last, got.kind, got.button, got.pos_x,
                               got.pos_y, got.event_time, got.last));
      end
      events_seen++;
    end
  end

  // Watchdog: a hung block ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic mouse_word_t report_word(input int dx, input int dy,
                                              input logic [BTN_W-1:0] buttons,
                                              input logic [STAMP_W-1:0] stamp);
    mouse_word_t w;
    w.op      = OP_REPORT;
    w.dx      = DELTA_W'(dx);
    w.dy      = DELTA_W'(dy);
    w.buttons = buttons;
    w.stamp   = stamp;
    return w;
  endfunction

  function automatic logic signed [DELTA_W-1:0] random_delta();
    int d;
    case ($urandom_range(9))
      0, 1, 2:    d = 0;
      3, 4, 5, 6: d = int'($urandom_range(16)) - 8;
      7, 8:       d = int'($urandom_range(400)) - 200;
      default:    d = int'($urandom_range((1 << DELTA_W) - 1));
    endcase
    return DELTA_W'(d);
  endfunction

  // Mostly reports with small moves, buttons that change now and then and
  // stamps that creep upward; the rest is flushes, full-range deltas and
  // stamps that jump anywhere.
  function automatic mouse_word_t random_word();
    mouse_word_t w;
    w.op = ($urandom_range(99) < 12) ? OP_FLUSH : OP_REPORT;
    w.dx = random_delta();
    w.dy = random_delta();
    if ($urandom_range(99) < 8) gen_stamp = $urandom();
    else gen_stamp += STAMP_W'($urandom_range(40, 1));
    w.stamp = gen_stamp;
    if (w.op == OP_FLUSH) begin
      // A flush ignores its other fields, so fill them with noise.
      w.buttons = BTN_W'($urandom_range(7));
    end else begin
      if ($urandom_range(99) < 30) gen_buttons = BTN_W'($urandom_range(7));
      w.buttons = gen_buttons;
    end
    return w;
  endfunction

  // Waits until the sender has nothing left, every owed event has arrived and
  // a word with no result has had time to finish.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || owed_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      CFG_THRESHOLD:     accel_thr  = value & ((1 << THR_W) - 1);
      CFG_NUMERATOR:     accel_num  = value & ((1 << NUM_W) - 1);
      CFG_DENOMINATOR:   accel_den  = value & ((1 << DEN_W) - 1);
      CFG_SCREEN_WIDTH:  scr_width  = value & ((1 << SIZE_W) - 1);
      CFG_SCREEN_HEIGHT: scr_height = value & ((1 << SIZE_W) - 1);
      default: ;
    endcase
  endtask

  // Writes all five registers. With stray set it also writes the indexes past
  // the last register, which the block must ignore.
  task automatic configure(input int thr, input int num, input int den,
                           input int width, input int height, input bit stray);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_NUMERATOR, num);
    write_reg(CFG_DENOMINATOR, den);
    write_reg(CFG_SCREEN_WIDTH, width);
    write_reg(CFG_SCREEN_HEIGHT, height);
    if (stray) begin
      for (int k = int'(CFG_SCREEN_HEIGHT) + 1; k < (1 << CFG_IDX_W); k++)
        write_reg(CFG_IDX_W'(k), int'($urandom_range((1 << CFG_DATA_W) - 1)));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    @(negedge clk);
    repeat (count) pending_words.push_back(random_word());
    settle();
  endtask

  initial begin : stimulus
    mouse_word_t w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset settings: threshold 2, ratio 2/1, 1024x768.
    // Sender idles 16 percent of the time, receiver 83 percent.
    tx_idle_pct = 16;
    rx_idle_pct = 83;
    // No move, no button change: nothing comes out.
    pending_words.push_back(report_word(0, 0, 3'b111, 32'd10));
    // A move below the threshold only makes motion pending.
    pending_words.push_back(report_word(1, 0, 3'b111, 32'd20));
    // Flush with motion pending, then a flush with nothing pending.
    w = report_word(0, 0, 3'b111, 32'd0);
    w.op = OP_FLUSH;
    pending_words.push_back(w);
    pending_words.push_back(w);
    // Largest positive X clamps to the right edge; button 1 goes down.
    pending_words.push_back(report_word(2047, 0, 3'b011, 32'd30));
    // Most negative deltas: X to the left edge, Y down to the bottom row;
    // buttons 2 and 3 go down, giving motion plus two presses.
    pending_words.push_back(report_word(-2048, -2048, 3'b000, 32'd40));
    // Largest positive Y moves to the top row; all three buttons come up.
    pending_words.push_back(report_word(0, 2047, 3'b111, 32'hFFFF_FFFF));
    // Magnitude equal to the threshold is not scaled, one above it is.
    pending_words.push_back(report_word(2, -3, 3'b111, 32'd50));
    pending_words.push_back(report_word(-1, 3, 3'b101, 32'd60));
    // A move onto the left edge, then a push against it that leaves the position
    // unchanged but still counts as motion, which the next button change must emit.
    pending_words.push_back(report_word(-5, 0, 3'b101, 32'd70));
    pending_words.push_back(report_word(-2048, 0, 3'b101, 32'd80));
    pending_words.push_back(report_word(0, 0, 3'b111, 32'd90));
    // A flush whose ignored fields are all ones.
    w = report_word(-1, -1, 3'b111, 32'hFFFF_FFFF);
    w.op = OP_FLUSH;
    pending_words.push_back(w);
    pending_words.push_back(report_word(0, 0, 3'b110, 32'd0));
    pending_words.push_back(report_word(7, -7, 3'b111, 32'h8000_0000));
    w.dx = 12'sd0;
    w.dy = 12'sd0;
    w.buttons = 3'b000;
    pending_words.push_back(w);
    settle();

    // Threshold at its top disables acceleration; a screen as large as the coordinates carry.
    configure((1 << THR_W) - 1, 255, 255, 4096, 4096, 1'b0);
    run_random(60);

    // Every delta scaled by 255 on a one-pixel screen.
    configure(0, 255, 1, 1, 1, 1'b0);
    run_random(60);

    // Sender now idles 83 percent of the time, receiver 16 percent.
    tx_idle_pct = 83;
    rx_idle_pct = 16;
    // Sizes beyond what the coordinates carry are capped at the top value.
    configure(0, 1, 255, (1 << SIZE_W) - 1, (1 << SIZE_W) - 1, 1'b0);
    run_random(60);

    // A zero denominator acts as one and zero sizes pin the pointer at zero;
    // writes to indexes past the list must change nothing.
    configure(5, 200, 0, 0, 0, 1'b1);
    run_random(60);

    // Neither side idles from here on.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(int'($urandom_range(20)), int'($urandom_range(255, 1)),
              int'($urandom_range(255, 1)), int'($urandom_range(4096, 1)),
              int'($urandom_range(4096, 1)), 1'b1);
    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block backs up and stalls its input.
    hold_asked = hold_asked + 1;
    run_random(60);

    // Register data with bits above each register's width, which are dropped.
    configure(int'($urandom_range((1 << CFG_DATA_W) - 1)),
              int'($urandom_range((1 << CFG_DATA_W) - 1)) | 1,
              int'($urandom_range((1 << CFG_DATA_W) - 1)) | 1, 640, 480, 1'b0);
    run_random(60);

    if (owed_events.size() != 0)
      note_error($sformatf("%0d expected results never arrived", owed_events.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pep_pkg.sv
design/pep_div.sv
design/pep_datapath.sv
design/pep_ctrl.sv
design/pointer_event_processor_core.sv
dv/pointer_event_processor_core_tb.sv
